/* hw/rtl/mcpwc_pkg.sv */
package mcpwc_pkg;

  // Fixed field widths of the streams and the period register
  localparam int CAP_W     = 16;
  localparam int CHAN_W    = 2;
  localparam int PERIOD_W  = 17;
  localparam int WIDTH_W   = 22;
  localparam int CNT_MAX_W = 8;
  localparam int PROD_W    = CNT_MAX_W + PERIOD_W;
  localparam int UP_W      = PROD_W + 1;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  // Kind of an input transfer
  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  // Update request from the control path to one channel
  typedef struct packed {
    logic             capture;
    logic             tick;
    logic [CAP_W-1:0] value;
  } chan_cmd_t;

  // State of one channel as seen by the width unit
  typedef struct packed {
    logic                 high;
    logic [CAP_W-1:0]     stamp;
    logic [CNT_MAX_W-1:0] count;
  } chan_stat_t;

endpackage

/* hw/rtl/multi_channel_pulse_width_capture.sv */
// Pulse width capture for up to NUM_CHANNELS receiver inputs. Each input transfer is a
// capture edge (channel plus latched counter value) or a counter overflow tick. The
// first edge on a channel records the rise stamp; the next one returns
// fall - rise + overflows * counter_period, clamped at zero and saturated at 22 bits.
// A channel that sees more than OVERFLOW_LIMIT ticks while high has its stamp zeroed
// and keeps measuring. Throughput is one transfer per clock: a transfer is applied to the
// channel registers and the width unit while it sits in the input register, and its
// result enters the output register at the edge that applies it. The input stalls only
// when a falling edge waits for an output register that still holds an untaken result.
// Write counter_period only while idle.
module multi_channel_pulse_width_capture #(
  parameter int NUM_CHANNELS   = 4,
  parameter int COUNTER_BITS   = 16,
  parameter int OVERFLOW_LIMIT = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,    // counter_period
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] channel, [17:2] capture_value, rest zero
  input  logic        s_axis_tuser,   // [0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [1:0] channel_out, [23:2] pulse_width
);
  import mcpwc_pkg::*;

  localparam int SW = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
  localparam logic [CAP_W-1:0] CAP_MASK = CAP_W'((64'(1) << SW) - 64'(1));
  localparam logic [PERIOD_W-1:0] PERIOD_RESET =
    PERIOD_W'((64'(1) << COUNTER_BITS) & 64'h1FFFF);

  logic [PERIOD_W-1:0] period_q;

  logic              in_valid_q;
  func_e             in_func_q;
  logic [CHAN_W-1:0] in_chan_q;
  logic [CAP_W-1:0]  in_cap_q;

  logic               out_valid_q;
  logic [CHAN_W-1:0]  out_chan_q;
  logic [WIDTH_W-1:0] out_width_q;

  chan_cmd_t             cmd  [NUM_CHANNELS];
  chan_stat_t            stat [NUM_CHANNELS];
  chan_stat_t            sel_stat;
  logic [NUM_CHANNELS-1:0] high_vec;

  logic               is_edge;
  logic               is_tick;
  logic               ch_hit;
  logic               produce;
  logic               proc_fire;
  logic [CAP_W-1:0]   cap_m;
  logic [WIDTH_W-1:0] width;

  // Period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Decode the held transfer
  assign is_edge = (in_func_q == FUNC_EDGE);
  assign is_tick = (in_func_q == FUNC_TICK);
  assign ch_hit  = 32'(in_chan_q) < NUM_CHANNELS;
  assign cap_m   = in_cap_q & CAP_MASK;

  // Pick the addressed channel's state
  always_comb begin
    sel_stat = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(in_chan_q) == i) begin
        sel_stat = stat[i];
      end
    end
  end

  // Apply the held transfer unless its result has nowhere to go
  assign produce       = in_valid_q && is_edge && ch_hit && sel_stat.high;
  assign proc_fire     = in_valid_q && (!produce || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= func_e'(s_axis_tuser);
      in_chan_q <= s_axis_tdata[1:0];
      in_cap_q  <= s_axis_tdata[17:2];
    end
  end

  // Channel cells
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    assign cmd[i].capture = proc_fire && is_edge && (32'(in_chan_q) == i);
    assign cmd[i].tick    = proc_fire && is_tick;
    assign cmd[i].value   = cap_m;
    assign high_vec[i]    = stat[i].high;

    mcpwc_chan #(
      .COUNTER_BITS   (COUNTER_BITS),
      .OVERFLOW_LIMIT (OVERFLOW_LIMIT)
    ) u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[i]),
      .stat_o (stat[i])
    );
  end

  mcpwc_width u_width (
    .cap_i    (cap_m),
    .stamp_i  (sel_stat.stamp),
    .count_i  (sel_stat.count),
    .period_i (period_q),
    .width_o  (width)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && produce) begin
      out_chan_q  <= in_chan_q;
      out_width_q <= width;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_width_q, out_chan_q};

`ifndef NO_ASSERTIONS
  // A result only ever comes from a capture edge
  a_result_from_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && produce) |-> (in_func_q == FUNC_EDGE))
    else $error("result loaded from a tick transfer");

  // A held transfer that is not applied stays in the input register
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(in_cap_q) && $stable(in_chan_q)))
    else $error("stalled input transfer lost");

  // A falling edge returns exactly one channel to low
  a_fall_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && produce) |=> ($countones(high_vec) == $past($countones(high_vec)) - 1))
    else $error("falling edge did not clear its channel");

  // A tick never changes which channels are high
  a_tick_keeps_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && is_tick) |=> (high_vec == $past(high_vec)))
    else $error("tick changed a channel level");
`endif

endmodule

/* hw/rtl/mcpwc_chan.sv */
module mcpwc_chan #(
  parameter int COUNTER_BITS   = 16,
  parameter int OVERFLOW_LIMIT = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mcpwc_pkg::chan_cmd_t   cmd_i,
  output mcpwc_pkg::chan_stat_t  stat_o
);
  import mcpwc_pkg::*;

  localparam int SW = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
  localparam int CW = $clog2(OVERFLOW_LIMIT + 1);
  localparam logic [CW-1:0] LIMIT = CW'(OVERFLOW_LIMIT);

  logic          high_q, high_d;
  logic [SW-1:0] stamp_q, stamp_d;
  logic [CW-1:0] count_q, count_d;
  logic          stamp_we;

  // Rise on a low channel, fall on a high one; ticks age a high channel
  always_comb begin
    high_d   = high_q;
    stamp_d  = stamp_q;
    count_d  = count_q;
    stamp_we = 1'b0;
    if (cmd_i.capture) begin
      if (!high_q) begin
        high_d   = 1'b1;
        stamp_d  = cmd_i.value[SW-1:0];
        stamp_we = 1'b1;
      end else begin
        high_d  = 1'b0;
        count_d = '0;
      end
    end else if (cmd_i.tick && high_q) begin
      if (count_q >= LIMIT) begin
        // discard a pulse that has run too long, stay high
        stamp_d  = '0;
        stamp_we = 1'b1;
        count_d  = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q  <= 1'b0;
      count_q <= '0;
    end else begin
      high_q  <= high_d;
      count_q <= count_d;
    end
  end

  // Stamp is only read while high, and going high writes it
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_q <= stamp_d;
    end
  end

  assign stat_o.high  = high_q;
  assign stat_o.stamp = CAP_W'(stamp_q);
  assign stat_o.count = CNT_MAX_W'(count_q);

endmodule

/* hw/rtl/mcpwc_width.sv */
module mcpwc_width (
  input  logic [mcpwc_pkg::CAP_W-1:0]     cap_i,
  input  logic [mcpwc_pkg::CAP_W-1:0]     stamp_i,
  input  logic [mcpwc_pkg::CNT_MAX_W-1:0] count_i,
  input  logic [mcpwc_pkg::PERIOD_W-1:0]  period_i,
  output logic [mcpwc_pkg::WIDTH_W-1:0]   width_o
);
  import mcpwc_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [UP_W-1:0]   up;
  logic [UP_W-1:0]   rise;
  logic [UP_W-1:0]   diff;

  // Fall time extended by the overflow periods
  assign prod = PROD_W'(count_i) * PROD_W'(period_i);
  assign up   = UP_W'(cap_i) + UP_W'(prod);
  assign rise = UP_W'(stamp_i);
  assign diff = up - rise;

  // Clamp at zero, saturate at the top of the field
  always_comb begin
    if (up < rise) begin
      width_o = '0;
    end else if (diff > UP_W'(WIDTH_MAX)) begin
      width_o = WIDTH_MAX;
    end else begin
      width_o = diff[WIDTH_W-1:0];
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mcpwc_pkg::*;

  localparam int NUM_CH           = 4;
  localparam int OVF_LIMIT        = 63;
  localparam int STALL_PCT        = 38;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int NUM_ROWS         = 18;
  localparam int NUM_PHASES       = 5;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd65536;

  // Result fields packed as on m_axis_tdata: channel in the low bits
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [CHAN_W-1:0]  chan;
  } pulse_t;

  // One line of the directed stimulus; fixed rows carry a hand-worked width
  typedef struct {
    func_e              func;
    logic [CHAN_W-1:0]  chan;
    logic [CAP_W-1:0]   cap;
    int                 reps;
    bit                 fixed;
    logic [WIDTH_W-1:0] width;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic [23:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [23:0]         m_axis_tdata;

  // Shadow channel state and period register
  bit                  ch_high [NUM_CH];
  logic [CAP_W-1:0]    ch_rise [NUM_CH];
  int unsigned         ch_ovf  [NUM_CH];
  logic [PERIOD_W-1:0] period_q = PERIOD_RESET;

  pulse_t pulse_q[$];
  int     error_count    = 0;
  int     items_sent     = 0;
  int     widths_checked = 0;
  int     periods_used   = 0;
  int     quiet_cycles   = 0;
  bit     steady         = 1'b0;

  multi_channel_pulse_width_capture u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the shadow channels by one transfer; return 1 when a pulse ends
  function automatic bit predict_pulse(input func_e func, input logic [CHAN_W-1:0] chan,
                                       input logic [CAP_W-1:0] cap, output pulse_t pulse);
    longint unsigned up;
    longint unsigned w;
    pulse = '0;
    if (func == FUNC_TICK) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (ch_high[i]) begin
          // a channel held high too long restarts from a zero stamp
          if (ch_ovf[i] >= OVF_LIMIT) begin
            ch_rise[i] = '0;
            ch_ovf[i]  = 0;
          end else begin
            ch_ovf[i]++;
          end
        end
      end
      return 1'b0;
    end
    if (!ch_high[chan]) begin
      ch_rise[chan] = cap;
      ch_high[chan] = 1'b1;
      return 1'b0;
    end
    up = 64'(cap) + 64'(ch_ovf[chan]) * 64'(period_q);
    w  = (up < 64'(ch_rise[chan])) ? 64'd0 : up - 64'(ch_rise[chan]);
    if (w > 64'(WIDTH_MAX)) w = 64'(WIDTH_MAX);
    pulse.chan    = chan;
    pulse.width   = w[WIDTH_W-1:0];
    ch_ovf[chan]  = 0;
    ch_high[chan] = 1'b0;
    return 1'b1;
  endfunction

  // Offer one transfer after a random gap and hold it until taken
  task automatic send_item(input func_e func, input logic [CHAN_W-1:0] chan,
                           input logic [CAP_W-1:0] cap, input bit fixed,
                           input logic [WIDTH_W-1:0] fixed_width);
    pulse_t pulse;
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, cap, chan};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (predict_pulse(func, chan, cap, pulse)) begin
      if (fixed) pulse.width = fixed_width;
      pulse_q.push_back(pulse);
    end
  endtask

  // Drain the block, let the pipeline settle, then write the period register
  task automatic set_period(input logic [PERIOD_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    period_q = value;
    periods_used++;
  endtask

  // Stall the result stream at random
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // Compare each result transfer with the oldest predicted pulse
  always @(posedge clk_i) begin
    pulse_t seen;
    pulse_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (pulse_q.size() == 0) begin
        $error("unexpected result: channel_out %0d pulse_width %0d", seen.chan, seen.width);
        error_count++;
      end else begin
        want = pulse_q.pop_front();
        widths_checked++;
        if (seen.chan !== want.chan) begin
          $error("channel_out: expected %0d, actual %0d", want.chan, seen.chan);
          error_count++;
        end
        if (seen.width !== want.width) begin
          $error("pulse_width: expected %0d, actual %0d", want.width, seen.width);
          error_count++;
        end
      end
    end
  end

  // Drop the run when neither stream moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t           rows [NUM_ROWS];
    logic [PERIOD_W-1:0] phase_periods [NUM_PHASES];
    func_e               func;
    logic [CHAN_W-1:0]   chan;
    logic [CAP_W-1:0]    cap;
    int                  tick_pct;

    // Directed rows, run with the reset period of 65536
    rows = '{
      '{FUNC_EDGE, 2'd0, 16'd100,   1,  1'b0, 22'd0},
      '{FUNC_EDGE, 2'd0, 16'd350,   1,  1'b1, 22'd250},
      '{FUNC_EDGE, 2'd1, 16'hFFFF,  1,  1'b0, 22'd0},
      // tick with channel and value fields that must be ignored
      '{FUNC_TICK, 2'd3, 16'hFFFF,  1,  1'b0, 22'd0},
      '{FUNC_EDGE, 2'd1, 16'd0,     1,  1'b1, 22'd1},
      '{FUNC_EDGE, 2'd2, 16'd5000,  1,  1'b0, 22'd0},
      // fall before rise with no overflow clamps to zero
      '{FUNC_EDGE, 2'd2, 16'd10,    1,  1'b1, 22'd0},
      '{FUNC_EDGE, 2'd3, 16'd0,     1,  1'b0, 22'd0},
      '{FUNC_EDGE, 2'd3, 16'hFFFF,  1,  1'b1, 22'd65535},
      '{FUNC_EDGE, 2'd0, 16'hABCD,  1,  1'b0, 22'd0},
      '{FUNC_TICK, 2'd2, 16'h5A5A,  2,  1'b0, 22'd0},
      '{FUNC_EDGE, 2'd0, 16'h1234,  1,  1'b0, 22'd0},
      // most overflows a channel keeps: exactly the widest result
      '{FUNC_EDGE, 2'd2, 16'd0,     1,  1'b0, 22'd0},
      '{FUNC_TICK, 2'd0, 16'd0,     63, 1'b0, 22'd0},
      '{FUNC_EDGE, 2'd2, 16'hFFFF,  1,  1'b1, 22'h3FFFFF},
      // one tick past the limit zeroes the stamp while the channel stays high
      '{FUNC_EDGE, 2'd1, 16'd40000, 1,  1'b0, 22'd0},
      '{FUNC_TICK, 2'd1, 16'd0,     64, 1'b0, 22'd0},
      '{FUNC_EDGE, 2'd1, 16'd7,     1,  1'b1, 22'd7}
    };

    // Smallest, zero, largest, mid-range and reset periods
    phase_periods    = '{17'd1, 17'd0, 17'h1FFFF, 17'd0, PERIOD_RESET};
    phase_periods[3] = 17'($urandom_range(2, 65535));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_period(PERIOD_RESET);
    foreach (rows[r]) begin
      repeat (rows[r].reps) begin
        send_item(rows[r].func, rows[r].chan, rows[r].cap, rows[r].fixed, rows[r].width);
      end
    end

    // Random phases; tick-heavy traffic under the largest period drives saturation
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_period(phase_periods[p]);
      steady   = (p == 3);
      tick_pct = (p == 2) ? $urandom_range(80, 95) : $urandom_range(10, 60);
      repeat (RANDOM_PER_PHASE) begin
        func = ($urandom_range(99) < tick_pct) ? FUNC_TICK : FUNC_EDGE;
        chan = 2'($urandom_range(NUM_CH - 1));
        case ($urandom_range(7))
          0:       cap = '0;
          1:       cap = '1;
          default: cap = 16'($urandom_range(65535));
        endcase
        send_item(func, chan, cap, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Hold off until every pulse is back, then let the pipeline empty
    s_axis_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d capture and tick transfers, checked %0d pulse widths", items_sent,
             widths_checked);
    $display("over %0d counter periods, with random stalls on both streams", periods_used);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
